FILE: src/gcic_pkg.sv
// ----------------------------------------------------------------------------
// gcic_pkg: shared types and constants for grid cell index conversion
// Widths of the coordinate, index and count fields, the stage record that
// travels down the cell chain, and small helper functions.
// ----------------------------------------------------------------------------
package gcic_pkg;

  localparam int COORD_BITS   = 10;
  localparam int NUM_DIMS     = 3;
  localparam int INDEX_BITS   = 30;
  localparam int COUNT_BITS   = 11;
  localparam int CFG_IDX_BITS = 2;
  localparam int DIM_IDX_BITS = 2;
  localparam int DIV_CELLS    = NUM_DIMS * INDEX_BITS;

  // Request codes.
  localparam logic REQ_TO_INDEX = 1'b0;
  localparam logic REQ_TO_COORD = 1'b1;

  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
  localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [INDEX_BITS-1:0] index_t;

  // One transaction in flight. For coordinate-to-index requests, sr holds the
  // finished index. For index-to-coordinate requests, rem and sr are the
  // partial remainder and the dividend/quotient shift register.
  typedef struct packed {
    logic                        valid;
    logic                        mode;
    logic                        err;
    count_t                      rem;
    index_t                      sr;
    coord_t [NUM_DIMS-1:0]       coord;
  } stage_t;

  // A count written as zero behaves as one.
  function automatic count_t eff_count(input count_t v);
    eff_count = (v == '0) ? count_t'(1) : v;
  endfunction

  // Closes one division of an index-to-coordinate request: the remainder becomes
  // coordinate d, saturated when it does not fit, and restarts at zero.
  function automatic stage_t capture(input stage_t s, input logic [DIM_IDX_BITS-1:0] d);
    stage_t r;
    logic   wide;
    r    = s;
    wide = (s.rem > count_t'(COORD_MAX));
    if (s.mode == REQ_TO_COORD) begin
      r.coord[d] = wide ? COORD_MAX : s.rem[COORD_BITS-1:0];
      r.err      = s.err | wide;
      r.rem      = '0;
    end
    capture = r;
  endfunction

endpackage

FILE: src/gcic_fold.sv
// ----------------------------------------------------------------------------
// gcic_fold: coordinate folding front end
// Two registered multiply-add steps that fold the coordinates into a linear
// index and check each coordinate against its count, or pass an index through.
// ----------------------------------------------------------------------------
module gcic_fold (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic                    req_type,
  input  gcic_pkg::coord_t        coord_in0,
  input  gcic_pkg::coord_t        coord_in1,
  input  gcic_pkg::coord_t        coord_in2,
  input  gcic_pkg::index_t        index_in,
  input  gcic_pkg::count_t        cnt0,
  input  gcic_pkg::count_t        cnt1,
  input  gcic_pkg::count_t        cnt2,
  output gcic_pkg::stage_t        stg_out
);

  localparam int ACC1_BITS = gcic_pkg::COORD_BITS + gcic_pkg::COUNT_BITS + 1;
  localparam int ACC2_BITS = ACC1_BITS + gcic_pkg::COUNT_BITS;

  logic                   v1_r;
  logic                   mode1_r;
  logic                   err1_r;
  logic [ACC1_BITS-1:0]   acc1_r;
  gcic_pkg::coord_t       c2_r;
  gcic_pkg::index_t       idx1_r;
  logic [ACC1_BITS-1:0]   acc1_nxt;
  logic                   err1_nxt;
  logic [ACC2_BITS-1:0]   acc2;
  logic                   err2;
  gcic_pkg::stage_t       stg_nxt;
  gcic_pkg::stage_t       stg_r;

  assign acc1_nxt = ACC1_BITS'(coord_in0) * ACC1_BITS'(cnt1) + ACC1_BITS'(coord_in1);
  assign err1_nxt = (gcic_pkg::count_t'(coord_in0) >= cnt0) |
                    (gcic_pkg::count_t'(coord_in1) >= cnt1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
    if (adv) begin
      mode1_r <= req_type;
      err1_r  <= err1_nxt;
      acc1_r  <= acc1_nxt;
      c2_r    <= coord_in2;
      idx1_r  <= index_in;
    end
  end

  assign acc2 = ACC2_BITS'(acc1_r) * ACC2_BITS'(cnt2) + ACC2_BITS'(c2_r);
  assign err2 = err1_r | (gcic_pkg::count_t'(c2_r) >= cnt2) |
                (acc2 > ACC2_BITS'(gcic_pkg::INDEX_MAX));

  always_comb begin
    stg_nxt       = '0;
    stg_nxt.valid = v1_r;
    stg_nxt.mode  = mode1_r;
    if (mode1_r == gcic_pkg::REQ_TO_INDEX) begin
      stg_nxt.err = err2;
      stg_nxt.sr  = (acc2 > ACC2_BITS'(gcic_pkg::INDEX_MAX)) ? gcic_pkg::INDEX_MAX
                                                             : acc2[gcic_pkg::INDEX_BITS-1:0];
    end else begin
      stg_nxt.sr  = idx1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
    end else if (adv) begin
      stg_r <= stg_nxt;
    end
  end

  assign stg_out = stg_r;

endmodule

FILE: src/gcic_div_cell.sv
// ----------------------------------------------------------------------------
// gcic_div_cell: one restoring-division bit step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit in. Other requests pass through.
// ----------------------------------------------------------------------------
module gcic_div_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  gcic_pkg::count_t      divisor,
  input  gcic_pkg::stage_t      stg_in,
  output gcic_pkg::stage_t      stg_out
);

  logic [gcic_pkg::COUNT_BITS:0] trial;
  logic                          ge;
  gcic_pkg::stage_t              stg_nxt;
  gcic_pkg::stage_t              stg_r;

  assign trial = {stg_in.rem, stg_in.sr[gcic_pkg::INDEX_BITS-1]};
  assign ge    = (trial >= {1'b0, divisor});

  always_comb begin
    stg_nxt = stg_in;
    if (stg_in.mode == gcic_pkg::REQ_TO_COORD) begin
      stg_nxt.rem = ge ? gcic_pkg::count_t'(trial - {1'b0, divisor})
                       : trial[gcic_pkg::COUNT_BITS-1:0];
      stg_nxt.sr  = {stg_in.sr[gcic_pkg::INDEX_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
    end else if (adv) begin
      stg_r <= stg_nxt;
    end
  end

  assign stg_out = stg_r;

endmodule

FILE: src/grid_cell_index_conversion_unit.sv
// ----------------------------------------------------------------------------
// grid_cell_index_conversion_unit: grid coordinate <-> linear index converter
// Row-major conversion between a three-dimensional cell coordinate and its
// linear index, with a range-error flag, built as a chain of division cells.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Carries
//   in_      input      in_valid/in_ready    req_type, coord_in0..2, index_in
//   out_     output     out_valid/out_ready  index_out, coord_out0..2, range_error
//   cfg_     input      cfg_we               cfg_index, cfg_wdata (cell counts)
//
// One transaction is accepted per cycle while in_ready is high. The pipeline is
// 2 fold stages, 90 division cells (one quotient bit per cell, 30 per dimension)
// and the output register; throughput is one transaction per cycle while the
// output is not stalled.
// Reset (synchronous, active low) empties the pipeline and sets all counts to 1.
// A stall on the output freezes the whole chain; in_ready is low only while the
// output register holds a result that is not being taken.
// ----------------------------------------------------------------------------
module grid_cell_index_conversion_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_req_type,
  input  gcic_pkg::coord_t                    in_coord_in0,
  input  gcic_pkg::coord_t                    in_coord_in1,
  input  gcic_pkg::coord_t                    in_coord_in2,
  input  gcic_pkg::index_t                    in_index_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gcic_pkg::index_t                    out_index_out,
  output gcic_pkg::coord_t                    out_coord_out0,
  output gcic_pkg::coord_t                    out_coord_out1,
  output gcic_pkg::coord_t                    out_coord_out2,
  output logic                                out_range_error,
  input  logic                                cfg_we,
  input  logic [gcic_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  gcic_pkg::count_t                    cfg_wdata
);

  // Effective cell counts; a zero write is stored as one.
  gcic_pkg::count_t cnt_r [gcic_pkg::NUM_DIMS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gcic_pkg::NUM_DIMS; i++) begin
        cnt_r[i] <= gcic_pkg::count_t'(1);
      end
    end else if (cfg_we && (cfg_index < gcic_pkg::CFG_IDX_BITS'(gcic_pkg::NUM_DIMS))) begin
      cnt_r[cfg_index] <= gcic_pkg::eff_count(cfg_wdata);
    end
  end

  // The whole chain advances together whenever the output register can load.
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Folding front end: coordinates to index for one request type, plain
  // pass-through of the index for the other.
  gcic_pkg::stage_t link [gcic_pkg::DIV_CELLS+1];
  gcic_pkg::stage_t cell_in [gcic_pkg::DIV_CELLS];

  gcic_fold u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .req_type  (in_req_type),
    .coord_in0 (in_coord_in0),
    .coord_in1 (in_coord_in1),
    .coord_in2 (in_coord_in2),
    .index_in  (in_index_in),
    .cnt0      (cnt_r[0]),
    .cnt1      (cnt_r[1]),
    .cnt2      (cnt_r[2]),
    .stg_out   (link[0])
  );

  // Division chain: the last dimension is divided out first. At each section
  // boundary the remainder is captured as that dimension's coordinate and the
  // quotient left in the shift register becomes the next dividend.
  for (genvar k = 0; k < gcic_pkg::DIV_CELLS; k++) begin : g_cell
    localparam int SECT = k / gcic_pkg::INDEX_BITS;
    localparam int DIM  = gcic_pkg::NUM_DIMS - 1 - SECT;

    if ((k % gcic_pkg::INDEX_BITS == 0) && (k != 0)) begin : g_cap
      assign cell_in[k] = gcic_pkg::capture(link[k],
                                            gcic_pkg::DIM_IDX_BITS'(DIM + 1));
    end else begin : g_pass
      assign cell_in[k] = link[k];
    end

    gcic_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .divisor (cnt_r[DIM]),
      .stg_in  (cell_in[k]),
      .stg_out (link[k+1])
    );
  end

  // Final capture of dimension 0. A leftover quotient means the index was at or
  // above the total cell count.
  gcic_pkg::stage_t fin;
  gcic_pkg::stage_t fin_cap;

  always_comb begin
    fin_cap = gcic_pkg::capture(link[gcic_pkg::DIV_CELLS], '0);
    fin     = fin_cap;
    if (fin_cap.mode == gcic_pkg::REQ_TO_COORD) begin
      fin.err = fin_cap.err | (fin_cap.sr != '0);
    end
  end

  // Output register.
  gcic_pkg::index_t  index_r;
  gcic_pkg::coord_t  c0_r, c1_r, c2_r;
  logic              err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin.valid;
    end
    if (adv) begin
      index_r <= (fin.mode == gcic_pkg::REQ_TO_INDEX) ? fin.sr : '0;
      c0_r    <= (fin.mode == gcic_pkg::REQ_TO_COORD) ? fin.coord[0] : '0;
      c1_r    <= (fin.mode == gcic_pkg::REQ_TO_COORD) ? fin.coord[1] : '0;
      c2_r    <= (fin.mode == gcic_pkg::REQ_TO_COORD) ? fin.coord[2] : '0;
      err_r   <= fin.err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_index_out   = index_r;
  assign out_coord_out0  = c0_r;
  assign out_coord_out1  = c1_r;
  assign out_coord_out2  = c2_r;
  assign out_range_error = err_r;

endmodule

FILE: dv/grid_cell_index_conversion_checker.sv
// ----------------------------------------------------------------------------
// grid_cell_index_conversion_checker: result scoreboard for the converter
// Watches the request and result channels, predicts each result from the
// cell counts it sees written, and compares every field in order.
// ----------------------------------------------------------------------------
module grid_cell_index_conversion_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_req_type,
  input  gcic_pkg::coord_t                  in_coord_in0,
  input  gcic_pkg::coord_t                  in_coord_in1,
  input  gcic_pkg::coord_t                  in_coord_in2,
  input  gcic_pkg::index_t                  in_index_in,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  gcic_pkg::index_t                  out_index_out,
  input  gcic_pkg::coord_t                  out_coord_out0,
  input  gcic_pkg::coord_t                  out_coord_out1,
  input  gcic_pkg::coord_t                  out_coord_out2,
  input  logic                              out_range_error,
  input  logic                              cfg_we,
  input  logic [gcic_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  gcic_pkg::count_t                  cfg_wdata,
  output int                                fail_count,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    gcic_pkg::index_t idx;
    gcic_pkg::coord_t c0, c1, c2;
    logic             err;
  } conv_result_t;

  conv_result_t     result_queue[$];
  gcic_pkg::count_t cells[gcic_pkg::NUM_DIMS];

  assign pending = result_queue.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic longint unsigned eff(input gcic_pkg::count_t v);
    return (v == '0) ? 1 : v;
  endfunction

  function automatic conv_result_t convert(input logic rt, input gcic_pkg::coord_t a,
                                           input gcic_pkg::coord_t b,
                                           input gcic_pkg::coord_t c,
                                           input gcic_pkg::index_t ix);
    conv_result_t r;
    longint unsigned acc, n, rem, total, q;
    gcic_pkg::coord_t cs[gcic_pkg::NUM_DIMS];
    r = '{idx: '0, c0: '0, c1: '0, c2: '0, err: 1'b0};
    cs[0] = a; cs[1] = b; cs[2] = c;
    if (rt == gcic_pkg::REQ_TO_INDEX) begin
      acc = 0;
      for (int d = 0; d < gcic_pkg::NUM_DIMS; d++) begin
        n = eff(cells[d]);
        if (cs[d] >= n) r.err = 1'b1;
        acc = acc * n + cs[d];
        if (acc > gcic_pkg::INDEX_MAX) begin
          r.err = 1'b1;
          acc = longint'(gcic_pkg::INDEX_MAX) + 1;
        end
      end
      r.idx = (acc > gcic_pkg::INDEX_MAX) ? gcic_pkg::INDEX_MAX : gcic_pkg::index_t'(acc);
    end else begin
      rem = ix;
      total = eff(cells[0]) * eff(cells[1]) * eff(cells[2]);
      if (rem >= total) r.err = 1'b1;
      for (int d = gcic_pkg::NUM_DIMS - 1; d >= 0; d--) begin
        n = eff(cells[d]);
        q = rem % n;
        rem = rem / n;
        if (q > gcic_pkg::COORD_MAX) begin
          r.err = 1'b1;
          q = gcic_pkg::COORD_MAX;
        end
        cs[d] = gcic_pkg::coord_t'(q);
      end
      r.c0 = cs[0]; r.c1 = cs[1]; r.c2 = cs[2];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    conv_result_t w;
    if (!rst_n) begin
      for (int d = 0; d < gcic_pkg::NUM_DIMS; d++) cells[d] = gcic_pkg::count_t'(1);
      fail_count = 0;
    end else begin
      if (cfg_we && cfg_index < gcic_pkg::NUM_DIMS) cells[cfg_index] = cfg_wdata;
      if (in_valid && in_ready)
        result_queue.push_back(convert(in_req_type, in_coord_in0, in_coord_in1,
                                       in_coord_in2, in_index_in));
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          report("result with none expected, index_out", out_index_out, 0);
        end else begin
          w = result_queue.pop_front();
          if (out_index_out !== w.idx) report("index_out", out_index_out, w.idx);
          if (out_coord_out0 !== w.c0) report("coord_out0", out_coord_out0, w.c0);
          if (out_coord_out1 !== w.c1) report("coord_out1", out_coord_out1, w.c1);
          if (out_coord_out2 !== w.c2) report("coord_out2", out_coord_out2, w.c2);
          if (out_range_error !== w.err)
            report("range_error", out_range_error, w.err);
        end
      end
    end
  end
endmodule

FILE: dv/grid_cell_index_conversion_unit_tb.sv
// ----------------------------------------------------------------------------
// grid_cell_index_conversion_unit_tb: testbench top for the converter
// Drives directed and random conversion requests under several cell-count
// settings, with bursty input and a stalling output, and reports a verdict.
// ----------------------------------------------------------------------------
module grid_cell_index_conversion_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Drain waits allow well beyond the depth of the pipeline.
  localparam int LATENCY = 93;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0, in_ready;
  logic             in_req_type = 1'b0;
  gcic_pkg::coord_t in_coord_in0 = '0, in_coord_in1 = '0, in_coord_in2 = '0;
  gcic_pkg::index_t in_index_in = '0;
  logic             out_valid, out_ready = 1'b0;
  gcic_pkg::index_t out_index_out;
  gcic_pkg::coord_t out_coord_out0, out_coord_out1, out_coord_out2;
  logic             out_range_error;
  logic             cfg_we = 1'b0;
  logic [gcic_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  gcic_pkg::count_t cfg_wdata = '0;
  int               fail_count, pending;
  gcic_pkg::count_t cur_cells[gcic_pkg::NUM_DIMS];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  grid_cell_index_conversion_unit DUT (.*);
  grid_cell_index_conversion_checker u_checker (.*);

  // The receiver stalls at random per phase: some phases never stall, others do.
  int stall_pct = 0;
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Sends one transaction and holds it until the block accepts it.
  task automatic send(input logic rt, input gcic_pkg::coord_t a, input gcic_pkg::coord_t b,
                      input gcic_pkg::coord_t c, input gcic_pkg::index_t ix);
    in_valid    <= 1'b1;
    in_req_type <= rt;
    in_coord_in0 <= a;
    in_coord_in1 <= b;
    in_coord_in2 <= c;
    in_index_in <= ix;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid for a gap; a zero gap keeps valid high for back-to-back items.
  task automatic gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Waits for every expected result, then lets the pipe settle before a write.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_cells(input gcic_pkg::count_t n0, input gcic_pkg::count_t n1,
                             input gcic_pkg::count_t n2);
    gcic_pkg::count_t v[gcic_pkg::NUM_DIMS];
    v[0] = n0; v[1] = n1; v[2] = n2;
    for (int d = 0; d < gcic_pkg::NUM_DIMS; d++) begin
      cfg_we    <= 1'b1;
      cfg_index <= gcic_pkg::CFG_IDX_BITS'(d);
      cfg_wdata <= v[d];
      cur_cells[d] = (v[d] == 0) ? gcic_pkg::count_t'(1) : v[d];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Random coordinate mostly inside the current count, sometimes anywhere.
  function automatic gcic_pkg::coord_t rand_coord(input int d);
    if ($urandom_range(9) < 8) return gcic_pkg::coord_t'($urandom_range(cur_cells[d] - 1));
    return gcic_pkg::coord_t'($urandom);
  endfunction

  function automatic gcic_pkg::index_t rand_index();
    longint unsigned total;
    total = longint'(cur_cells[0]) * cur_cells[1] * cur_cells[2];
    if ($urandom_range(9) < 8)
      return gcic_pkg::index_t'({$urandom, $urandom} % total);
    return gcic_pkg::index_t'($urandom);
  endfunction

  task automatic random_phase(input int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        if (count > 0) begin
          if ($urandom_range(1))
            send(gcic_pkg::REQ_TO_INDEX, rand_coord(0), rand_coord(1), rand_coord(2),
                 gcic_pkg::index_t'($urandom));
          else
            send(gcic_pkg::REQ_TO_COORD, gcic_pkg::coord_t'($urandom),
                 gcic_pkg::coord_t'($urandom), gcic_pkg::coord_t'($urandom), rand_index());
          count--;
        end
      end
      gap($urandom_range(0, 6));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cur_cells = '{default: gcic_pkg::count_t'(1)};

    // Reset counts of one: only the origin is in range.
    send(gcic_pkg::REQ_TO_INDEX, '0, '0, '0, '0);
    send(gcic_pkg::REQ_TO_INDEX, gcic_pkg::COORD_MAX, gcic_pkg::COORD_MAX,
         gcic_pkg::COORD_MAX, '0);
    send(gcic_pkg::REQ_TO_COORD, '0, '0, '0, '0);
    send(gcic_pkg::REQ_TO_COORD, gcic_pkg::COORD_MAX, gcic_pkg::COORD_MAX,
         gcic_pkg::COORD_MAX, gcic_pkg::INDEX_MAX);
    drain();

    // Full grid: largest legal index in both directions, and the origin.
    write_cells(11'd1024, 11'd1024, 11'd1024);
    send(gcic_pkg::REQ_TO_INDEX, gcic_pkg::COORD_MAX, gcic_pkg::COORD_MAX,
         gcic_pkg::COORD_MAX, '0);
    send(gcic_pkg::REQ_TO_INDEX, '0, '0, '0, gcic_pkg::INDEX_MAX);
    send(gcic_pkg::REQ_TO_COORD, '0, '0, '0, gcic_pkg::INDEX_MAX);
    send(gcic_pkg::REQ_TO_COORD, '0, '0, '0, gcic_pkg::index_t'(30'h2AAAAAAA));
    drain();

    // Counts above the coordinate width force saturation and overflow.
    write_cells(11'd2047, 11'd2047, 11'd1025);
    send(gcic_pkg::REQ_TO_INDEX, gcic_pkg::COORD_MAX, gcic_pkg::COORD_MAX,
         gcic_pkg::COORD_MAX, '0);
    send(gcic_pkg::REQ_TO_COORD, '0, '0, '0, gcic_pkg::index_t'(30'd1024));
    send(gcic_pkg::REQ_TO_COORD, '0, '0, '0, gcic_pkg::INDEX_MAX);
    send(gcic_pkg::REQ_TO_COORD, '0, '0, '0, gcic_pkg::index_t'(30'h15555555));
    drain();

    // A count written as zero behaves as one.
    write_cells(11'd0, 11'd7, 11'd0);
    send(gcic_pkg::REQ_TO_INDEX, '0, gcic_pkg::coord_t'(6), '0, '0);
    send(gcic_pkg::REQ_TO_INDEX, gcic_pkg::coord_t'(1), gcic_pkg::coord_t'(7),
         gcic_pkg::coord_t'(1), '0);
    send(gcic_pkg::REQ_TO_COORD, '0, '0, '0, gcic_pkg::index_t'(6));
    send(gcic_pkg::REQ_TO_COORD, '0, '0, '0, gcic_pkg::index_t'(7));
    drain();

    // Random phases over a spread of grid shapes and stall levels.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_cells(11'd3, 11'd5, 11'd7);
        1: write_cells(11'd1024, 11'd1024, 11'd1024);
        2: write_cells(gcic_pkg::count_t'($urandom_range(1, 1024)),
                       gcic_pkg::count_t'($urandom_range(1, 1024)),
                       gcic_pkg::count_t'($urandom_range(1, 1024)));
        3: write_cells(11'd1, 11'd1, 11'd1);
        4: write_cells(11'd2047, 11'd1500, 11'd1100);
        default: write_cells(gcic_pkg::count_t'($urandom_range(0, 2047)),
                             gcic_pkg::count_t'($urandom_range(0, 64)),
                             gcic_pkg::count_t'($urandom_range(0, 2047)));
      endcase
      stall_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 70);
      random_phase(160);
      drain();
    end

    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
